// ===== src/sfh_pkg.sv =====
// Shared types, codes and constants of the supervision frame handshake.
package sfh_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  FLAG_RST = 8'h5c;
    localparam logic [7:0]  ADDR_RST = 8'h01;
    localparam logic [7:0]  CMD_CTRL_RST = 8'h03;
    localparam logic [7:0]  ANS_CTRL_RST = 8'h07;
    localparam logic [15:0] TIMEOUT_RST = 16'd5;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd3;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DONE = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        RS_START = 3'd0,
        RS_FLAG  = 3'd1,
        RS_ADDR  = 3'd2,
        RS_CTRL  = 3'd3,
        RS_CHECK = 3'd4,
        RS_STOP  = 3'd5
    } recog_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLAG        = 3'd0,
        REG_ADDRESS     = 3'd1,
        REG_CMD_CTRL    = 3'd2,
        REG_ANS_CTRL    = 3'd3,
        REG_TIMEOUT     = 3'd4,
        REG_RETRY_LIMIT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  flag_byte;
        logic [7:0]  address_byte;
        logic [7:0]  command_control;
        logic [7:0]  answer_control;
        logic [15:0] timeout_ticks;
        logic [3:0]  retry_limit;
    } cfg_t;

    // One queued job: either a full frame or a single status word.
    typedef struct packed {
        logic        send_frame;
        phase_t      status;
        logic [3:0]  retries;
    } job_t;

endpackage

// ===== src/sfh_ifs.sv =====
// Valid/ready channel interfaces of the supervision frame handshake.
interface sfh_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface sfh_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [1:0] link_status;
    logic [3:0] retries_used;
    logic       last;

    modport source (output valid, output tx_byte, output tx_valid, output link_status,
                    output retries_used, output last, input ready);
    modport sink (input valid, input tx_byte, input tx_valid, input link_status,
                  input retries_used, input last, output ready);
endinterface

interface sfh_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/supervision_frame_handshake_core.sv =====
// Top level of the supervision frame handshake sender.
//
//   channel  direction  carries
//   req      in         operation, rx_byte
//   rsp      out        tx_byte, tx_valid, link_status, retries_used, last
//   cfg      in         index, data (register write, always ready)
//
// An item is taken whenever the job queue has room; its state update is done
// in that same cycle by the front end. The output port moves one word per cycle
// while rsp.ready is high; a start or a retransmission sends five frame words,
// any other item one status word. Reset returns registers to their defaults and
// empties the queue. A stalled output fills the queue, and then req.ready drops.
module supervision_frame_handshake_core
    import sfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    sfh_req_if.sink  req,
    sfh_cfg_if.sink  cfg,
    sfh_rsp_if.source rsp
);

    cfg_t                             cfg_regs;
    logic                             push;
    job_t                             push_job;
    logic                             queue_full;
    logic                             pop;
    logic                             head_valid;
    job_t                             head_job;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count;

    assign cfg.ready = 1'b1;

    sfh_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_regs)
    );

    sfh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_regs),
        .in_valid     (req.valid),
        .in_operation (req.operation),
        .in_rx_byte   (req.rx_byte),
        .in_ready     (req.ready),
        .push         (push),
        .push_job     (push_job),
        .queue_full   (queue_full)
    );

    sfh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (queue_count)
    );

    sfh_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_regs),
        .head_valid       (head_valid),
        .head_job         (head_job),
        .pop              (pop),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_tx_byte      (rsp.tx_byte),
        .out_tx_valid     (rsp.tx_valid),
        .out_link_status  (rsp.link_status),
        .out_retries_used (rsp.retries_used),
        .out_last         (rsp.last)
    );

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("job queue count exceeds its depth");

    a_start_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.operation == OP_START) |=> queue_count != '0)
        else $error("accepted start left no job in the queue");

    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.tx_valid) |-> (rsp.last && rsp.tx_byte == 8'd0))
        else $error("status word is not a single zero-byte final word");

    a_frame_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.tx_valid) |-> rsp.link_status == PH_WAIT)
        else $error("frame word sent outside the waiting phase");
`endif

endmodule

// ===== src/sfh_cfg_regs.sv =====
// Configuration register bank of the supervision frame handshake.
module sfh_cfg_regs
    import sfh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_FLAG:        cfg_next.flag_byte = wr_data[7:0];
                REG_ADDRESS:     cfg_next.address_byte = wr_data[7:0];
                REG_CMD_CTRL:    cfg_next.command_control = wr_data[7:0];
                REG_ANS_CTRL:    cfg_next.answer_control = wr_data[7:0];
                REG_TIMEOUT:     cfg_next.timeout_ticks = wr_data;
                REG_RETRY_LIMIT: cfg_next.retry_limit = wr_data[3:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte <= FLAG_RST;
            cfg_reg.address_byte <= ADDR_RST;
            cfg_reg.command_control <= CMD_CTRL_RST;
            cfg_reg.answer_control <= ANS_CTRL_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.retry_limit <= RETRY_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/sfh_front.sv =====
// Front end: accepts items, runs recognizer, timer and retry logic, queues jobs.
module sfh_front
    import sfh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [1:0] in_operation,
    input  logic [7:0] in_rx_byte,
    output logic       in_ready,
    output logic       push,
    output job_t       push_job,
    input  logic       queue_full
);

    recog_t      recog_reg, recog_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  retry_reg, retry_next;
    logic        send_frame;

    function automatic recog_t recognize(recog_t s, logic [7:0] b, cfg_t c);
        logic [7:0] check;
        recog_t     fallback;
        check = c.address_byte ^ c.answer_control;
        fallback = (b == c.flag_byte) ? RS_FLAG : RS_START;
        case (s)
            RS_START: recognize = (b == c.flag_byte) ? RS_FLAG : RS_START;
            RS_FLAG:  recognize = (b == c.address_byte) ? RS_ADDR : fallback;
            RS_ADDR:  recognize = (b == c.answer_control) ? RS_CTRL : fallback;
            RS_CTRL:  recognize = (b == check) ? RS_CHECK : fallback;
            RS_CHECK: recognize = (b == c.flag_byte) ? RS_STOP : RS_START;
            default:  recognize = s;
        endcase
    endfunction

    assign in_ready = !queue_full;
    assign push = in_valid && in_ready;

    always_comb
    begin
        recog_next = recog_reg;
        phase_next = phase_reg;
        tick_next = tick_reg;
        retry_next = retry_reg;
        send_frame = 1'b0;
        if (push)
        begin
            case (op_t'(in_operation))
                OP_START:
                begin
                    recog_next = RS_START;
                    retry_next = '0;
                    phase_next = PH_WAIT;
                    tick_next = cfg.timeout_ticks;
                    send_frame = 1'b1;
                end
                OP_BYTE:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        recog_next = recognize(recog_reg, in_rx_byte, cfg);
                        if (recog_next == RS_STOP)
                        begin
                            phase_next = PH_DONE;
                            tick_next = '0;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (tick_reg > 16'd1)
                        begin
                            tick_next = tick_reg - 16'd1;
                        end
                        else if (retry_reg >= cfg.retry_limit)
                        begin
                            tick_next = '0;
                            phase_next = PH_FAIL;
                        end
                        else
                        begin
                            // Expiry with retries left: resend and re-arm the timer.
                            retry_next = retry_reg + 4'd1;
                            tick_next = cfg.timeout_ticks;
                            send_frame = 1'b1;
                        end
                    end
                end
                default:
                begin
                    recog_next = recog_reg;
                end
            endcase
        end
    end

    assign push_job.send_frame = send_frame;
    assign push_job.status = phase_next;
    assign push_job.retries = retry_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recog_reg <= RS_START;
            phase_reg <= PH_IDLE;
            tick_reg <= '0;
            retry_reg <= '0;
        end
        else
        begin
            recog_reg <= recog_next;
            phase_reg <= phase_next;
            tick_reg <= tick_next;
            retry_reg <= retry_next;
        end
    end

endmodule

// ===== src/sfh_queue.sv =====
// Short job queue between the front end and the frame emitter.
module sfh_queue
    import sfh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  job_t                       push_job,
    output logic                       full,
    input  logic                       pop,
    output logic                       head_valid,
    output job_t                       head_job,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job = entries[rd_ptr_reg];
    assign count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/sfh_back.sv =====
// Back end: expands queued jobs into output words through an output register.
module sfh_back
    import sfh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_tx_byte,
    output logic       out_tx_valid,
    output logic [1:0] out_link_status,
    output logic [3:0] out_retries_used,
    output logic       out_last
);

    localparam int IDX_W = $clog2(FRAME_BYTES);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       tx_byte_reg, tx_byte_next;
    logic             tx_valid_reg, tx_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [3:0]       retries_reg, retries_next;
    logic             last_reg, last_next;
    logic             load;
    logic             final_word;

    function automatic logic [7:0] frame_byte(logic [IDX_W-1:0] k, cfg_t c);
        if (k == '0 || k == IDX_W'(FRAME_BYTES - 1))
        begin
            frame_byte = c.flag_byte;
        end
        else if (k == IDX_W'(1))
        begin
            frame_byte = c.address_byte;
        end
        else if (k == IDX_W'(2))
        begin
            frame_byte = c.command_control;
        end
        else
        begin
            frame_byte = c.address_byte ^ c.command_control;
        end
    endfunction

    // The output register refills whenever it is empty or being drained and a job is queued.
    assign load = (!valid_reg || out_ready) && head_valid;
    assign final_word = !head_job.send_frame || (idx_reg == IDX_W'(FRAME_BYTES - 1));
    assign pop = load && final_word;

    always_comb
    begin
        idx_next = idx_reg;
        valid_next = valid_reg && !out_ready;
        tx_byte_next = tx_byte_reg;
        tx_valid_next = tx_valid_reg;
        status_next = status_reg;
        retries_next = retries_reg;
        last_next = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            tx_byte_next = head_job.send_frame ? frame_byte(idx_reg, cfg) : 8'd0;
            tx_valid_next = head_job.send_frame;
            status_next = head_job.status;
            retries_next = head_job.retries;
            last_next = final_word;
            idx_next = final_word ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_byte_reg <= tx_byte_next;
        tx_valid_reg <= tx_valid_next;
        status_reg <= status_next;
        retries_reg <= retries_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_tx_byte = tx_byte_reg;
    assign out_tx_valid = tx_valid_reg;
    assign out_link_status = status_reg;
    assign out_retries_used = retries_reg;
    assign out_last = last_reg;

endmodule
